>>> hdl/nsc_pkg.sv
package nsc_pkg;

    localparam int LINE_MAX = 256;
    localparam int POS_W = $clog2(LINE_MAX + 1);

    localparam int BYTE_W = 8;
    localparam int TAG_LEN = 5;
    localparam int TAG_W = TAG_LEN * BYTE_W;
    localparam int LEN_W = 9;

    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [TAG_W-1:0] TAG_RESET = 40'h474E474741;
    localparam int MIN_STAR_OFFSET = 3;

    typedef struct packed {
        logic              tag_found;
        logic              star_ok;
        logic              checksum_ok;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
        logic [LEN_W-1:0]  line_length;
        logic              overflow;
    } result_t;

endpackage

>>> hdl/nsc_input_stage.sv
module nsc_input_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nsc_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       advance,
    output logic                       in_valid,
    output logic [nsc_pkg::BYTE_W-1:0] in_byte
);
    import nsc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // The held byte leaves in the same cycle that a new one may enter.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte = byte_reg;

endmodule

>>> hdl/nsc_line_tracker.sv
module nsc_line_tracker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [nsc_pkg::TAG_W-1:0]  cfg_wdata,
    input  logic                       step,
    input  logic [nsc_pkg::BYTE_W-1:0] rx_byte,
    output nsc_pkg::result_t           result
);
    import nsc_pkg::*;

    logic [TAG_W-1:0]  tag_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              star_seen_reg, star_seen_next;
    logic              star_pos_ok_reg, star_pos_ok_next;
    logic [1:0]        hex_cnt_reg, hex_cnt_next;
    logic              hex_done_reg, hex_done_next;
    logic [BYTE_W-1:0] hex_val_reg, hex_val_next;
    logic [TAG_W-1:0]  recent_reg, recent_next;
    logic              tag_seen_reg, tag_seen_next;
    logic              ovf_reg, ovf_next;

    logic              is_hex;
    logic [3:0]        hex_digit;
    logic              star_ok;

    always_comb begin
        is_hex = 1'b1;
        hex_digit = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
            hex_digit = 4'(rx_byte - 8'h30);
        end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
            hex_digit = 4'(rx_byte - 8'h37);
        end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
            hex_digit = 4'(rx_byte - 8'h57);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        xor_next = xor_reg;
        star_seen_next = star_seen_reg;
        star_pos_ok_next = star_pos_ok_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_done_next = hex_done_reg;
        hex_val_next = hex_val_reg;
        recent_next = recent_reg;
        tag_seen_next = tag_seen_reg;
        ovf_next = ovf_reg;
        if (rx_byte == CH_NEWLINE) begin
            pos_next = '0;
            xor_next = '0;
            star_seen_next = 1'b0;
            star_pos_ok_next = 1'b0;
            hex_cnt_next = '0;
            hex_done_next = 1'b0;
            hex_val_next = '0;
            recent_next = '0;
            tag_seen_next = 1'b0;
            ovf_next = 1'b0;
        end else if (pos_reg >= POS_W'(LINE_MAX)) begin
            // Bytes past the buffer size only mark the line as overflowed.
            ovf_next = 1'b1;
        end else begin
            if (!star_seen_reg) begin
                if (rx_byte == CH_STAR) begin
                    star_seen_next = 1'b1;
                    star_pos_ok_next = (pos_reg >= POS_W'(MIN_STAR_OFFSET));
                end else if (pos_reg != '0) begin
                    xor_next = xor_reg ^ rx_byte;
                end
            end else if (!hex_done_reg) begin
                if (!is_hex) begin
                    hex_done_next = 1'b1;
                end else begin
                    hex_val_next = {hex_val_reg[BYTE_W-5:0], hex_digit};
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    if (hex_cnt_reg != 2'd0) begin
                        hex_done_next = 1'b1;
                    end
                end
            end
            recent_next = {recent_reg[TAG_W-BYTE_W-1:0], rx_byte};
            pos_next = pos_reg + POS_W'(1);
            // The window holds only this line's bytes once five are stored.
            if (pos_reg >= POS_W'(TAG_LEN - 1) && recent_next == tag_reg) begin
                tag_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= TAG_RESET;
            pos_reg <= '0;
            xor_reg <= '0;
            star_seen_reg <= 1'b0;
            star_pos_ok_reg <= 1'b0;
            hex_cnt_reg <= '0;
            hex_done_reg <= 1'b0;
            hex_val_reg <= '0;
            recent_reg <= '0;
            tag_seen_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tag_reg <= cfg_wdata;
            end
            if (step) begin
                pos_reg <= pos_next;
                xor_reg <= xor_next;
                star_seen_reg <= star_seen_next;
                star_pos_ok_reg <= star_pos_ok_next;
                hex_cnt_reg <= hex_cnt_next;
                hex_done_reg <= hex_done_next;
                hex_val_reg <= hex_val_next;
                recent_reg <= recent_next;
                tag_seen_reg <= tag_seen_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    assign star_ok = star_seen_reg && star_pos_ok_reg;

    always_comb begin
        result.tag_found = tag_seen_reg;
        result.star_ok = star_ok;
        result.checksum_ok = star_ok && (hex_cnt_reg != 2'd0) &&
                             (xor_reg == hex_val_reg) && !ovf_reg;
        result.computed_sum = xor_reg;
        result.received_sum = hex_val_reg;
        result.line_length = LEN_W'(pos_reg);
        result.overflow = ovf_reg;
    end

endmodule

>>> hdl/nsc_result_stage.sv
module nsc_result_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  nsc_pkg::result_t load_data,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output nsc_pkg::result_t m_data
);
    import nsc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data = data_reg;

endmodule

>>> hdl/nmea_sentence_checksum_checker.sv
// Channel    Direction  Handshake          Payload
// s_         in         s_valid/s_ready    s_rx_byte[7:0]
// m_         out        m_valid/m_ready    tag, star, checksum flags, sums, length, overflow
// cfg_       in         cfg_we             cfg_wdata[39:0] (sentence tag)
//
// One byte is accepted per cycle while s_ready is high; it waits in the input register,
// then updates the running line registers, and a newline loads the result register.
// Reset clears all line state and loads the tag register with "GNGGA".
// Only a newline waits on the result register; other bytes keep flowing while
// a result is stalled, and the input register holds a newline until it frees.
module nmea_sentence_checksum_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [nsc_pkg::TAG_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nsc_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_tag_found,
    output logic                       m_star_ok,
    output logic                       m_checksum_ok,
    output logic [nsc_pkg::BYTE_W-1:0] m_computed_sum,
    output logic [nsc_pkg::BYTE_W-1:0] m_received_sum,
    output logic [nsc_pkg::LEN_W-1:0]  m_line_length,
    output logic                       m_overflow
);
    import nsc_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              advance;
    logic              is_newline;
    logic              out_free;
    result_t           line_result;
    result_t           out_data;

    assign is_newline = (in_byte == CH_NEWLINE);
    assign advance = in_valid && (!is_newline || out_free);

    nsc_input_stage u_input (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    nsc_line_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .rx_byte   (in_byte),
        .result    (line_result)
    );

    nsc_result_stage u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && is_newline),
        .load_data (line_result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_tag_found = out_data.tag_found;
    assign m_star_ok = out_data.star_ok;
    assign m_checksum_ok = out_data.checksum_ok;
    assign m_computed_sum = out_data.computed_sum;
    assign m_received_sum = out_data.received_sum;
    assign m_line_length = out_data.line_length;
    assign m_overflow = out_data.overflow;

    a_ok_needs_star: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> m_star_ok && !m_overflow)
        else $error("checksum_ok without a valid asterisk or with overflow");

    a_ok_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> m_computed_sum == m_received_sum)
        else $error("checksum_ok with differing sums");

    a_ovf_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_line_length == LEN_W'(LINE_MAX))
        else $error("overflowed line does not report the buffer size");

    a_newline_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && is_newline && out_free |=> m_valid)
        else $error("newline did not produce a result");

endmodule
